FILE: rtl/efla_pkg.sv
// Shared types and constants for the explicit free list heap allocator.
// Used by efla_ctrl, efla_dp, the top level and the checker; no dependencies.
`default_nettype none
package efla_pkg;

  localparam int unsigned HEAP_BYTES_DEF = 65536;
  localparam int unsigned WSIZE          = 4;
  localparam int unsigned DSIZE          = 8;
  localparam int unsigned MIN_BLK        = 2 * DSIZE;
  localparam int unsigned PRO_END        = 4 * WSIZE;
  localparam int unsigned CHUNK_W        = 17;
  localparam int unsigned CFG_AW         = 3;
  localparam logic [CHUNK_W-1:0] CHUNK_RST = CHUNK_W'(1 << 12);
  localparam logic [CFG_AW-1:0]  CFG_CHUNK_ADDR = '0;
  localparam logic [31:0] PRO_TAG = 32'(DSIZE) | 32'h1;
  localparam logic [31:0] EPI_TAG = 32'h1;

  typedef enum logic [1:0] {
    ACT_INIT  = 2'd0,
    ACT_ALLOC = 2'd1,
    ACT_FREE  = 2'd2,
    ACT_NONE  = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_OOM  = 2'd2,
    ST_NRDY = 2'd3
  } status_e;

  typedef enum logic [5:0] {
    OP_NOP, OP_CAPTURE, OP_PRO0, OP_PRO1, OP_PRO2, OP_PRO3,
    OP_GROW_CHK, OP_HDR, OP_FTR, OP_EPI,
    OP_MG_RDP, OP_MG_RDN, OP_MG_LATN, OP_MG_SUM, OP_MG_SETBP,
    OP_RM_PB, OP_RM_NB, OP_RM_RD0, OP_RM_RD1, OP_RM_LINKP, OP_RM_LINKN,
    OP_INS0, OP_INS1, OP_INS2,
    OP_A_START, OP_A_RDH, OP_A_RDNX, OP_A_NEXT, OP_A_FOUND, OP_A_MISS,
    OP_PL_START, OP_PL_ASZ, OP_PL_REM,
    OP_F_RD, OP_F_CHK, OP_SET_READY, OP_FINISH
  } dp_op_e;

  typedef struct packed {
    dp_op_e  op;
    logic    alloc;
    status_e st;
  } cmd_t;

  typedef struct packed {
    logic ready;
    logic req_zero;
    act_e act;
    logic ok;
    logic pa;
    logic na;
    logic fit;
    logic walk_end;
    logic split;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

FILE: rtl/efla_dp.sv
// Datapath: heap word memory, block/list registers and the result register.
// Depends on efla_pkg; driven by efla_ctrl through cmd_t, reports sts_t.
`default_nettype none
module efla_dp #(
  parameter int unsigned HEAP_BYTES = efla_pkg::HEAP_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  efla_pkg::cmd_t                cmd_i,
  output efla_pkg::sts_t                sts_o,
  input  logic [1:0]                    action_i,
  input  logic [16:0]                   request_bytes_i,
  input  logic [15:0]                   block_addr_i,
  input  logic [efla_pkg::CHUNK_W-1:0]  chunk_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [15:0]                   result_addr_o,
  output logic [1:0]                    status_o
);
  import efla_pkg::*;

  localparam int unsigned AW_RAW   = $clog2(HEAP_BYTES) + 1;
  localparam int unsigned W        = (AW_RAW > 18) ? AW_RAW : 18;
  localparam int unsigned DEPTH    = HEAP_BYTES / 4;
  localparam int unsigned WI       = $clog2(DEPTH);
  localparam int unsigned STEP_MAX = HEAP_BYTES / 16;
  localparam int unsigned SW       = $clog2(STEP_MAX + 2);

  logic [31:0] mem [DEPTH];
  logic [31:0] mem_q;

  logic [W-1:0] brk_q, head_q;
  logic         ready_q, out_valid_q;
  act_e         act_q;
  logic [16:0]  req_q;
  logic [15:0]  addr_q;
  logic [W-1:0] bp_q, sz_q, asz_q, csz_q, psz_q, pb_q, nsz_q, nb_q;
  logic [W-1:0] rm_q, p_q, n_q, walk_q;
  logic         pa_q, na_q, ok_q;
  logic [SW-1:0] steps_q;
  logic [15:0]  res_q, out_res_q;
  status_e      out_st_q;

  logic [W-1:0] mem_addr;
  logic         mem_we, mem_re;
  logic [31:0]  mem_wd;
  logic [W-1:0] mtag, chunk_eff, asize, addr_w;
  logic [17:0]  chunk_r, asize_r;
  logic         grow_fail, free_ok;
  logic [31:0]  tag_word;

  function automatic logic [W-1:0] tag_sz(logic [31:0] w);
    return {w[W-1:3], 3'b000};
  endfunction

  assign mtag     = tag_sz(mem_q);
  assign addr_w   = W'(addr_q);
  assign chunk_r  = ({1'b0, chunk_i} + 18'd7) & ~18'd7;
  assign chunk_eff = (chunk_r < 18'(MIN_BLK)) ? W'(MIN_BLK) : W'(chunk_r);
  assign asize_r  = ({1'b0, req_q} + 18'(DSIZE + 7)) & ~18'd7;
  assign asize    = (req_q <= 17'(DSIZE)) ? W'(MIN_BLK) : W'(asize_r);
  assign grow_fail = (brk_q > W'(HEAP_BYTES)) || (sz_q > W'(HEAP_BYTES) - brk_q);
  assign free_ok  = (addr_q[2:0] == 3'b000) && (addr_w >= W'(MIN_BLK)) &&
                    (addr_w < brk_q) && mem_q[0] && (mtag >= W'(MIN_BLK)) &&
                    (mtag <= brk_q - addr_w);
  assign tag_word = 32'(sz_q) | 32'(cmd_i.alloc);

  always_comb begin
    mem_addr = '0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_wd   = '0;
    unique case (cmd_i.op)
      OP_PRO0: begin mem_we = 1'b1; mem_addr = '0; mem_wd = '0; end
      OP_PRO1: begin mem_we = 1'b1; mem_addr = W'(WSIZE); mem_wd = PRO_TAG; end
      OP_PRO2: begin mem_we = 1'b1; mem_addr = W'(DSIZE); mem_wd = PRO_TAG; end
      OP_PRO3: begin mem_we = 1'b1; mem_addr = W'(PRO_END - WSIZE); mem_wd = EPI_TAG; end
      OP_HDR: begin mem_we = 1'b1; mem_addr = bp_q - W'(WSIZE); mem_wd = tag_word; end
      OP_FTR: begin mem_we = 1'b1; mem_addr = bp_q + sz_q - W'(DSIZE); mem_wd = tag_word; end
      OP_EPI: begin mem_we = 1'b1; mem_addr = bp_q + sz_q - W'(WSIZE); mem_wd = EPI_TAG; end
      OP_MG_RDP: begin mem_re = 1'b1; mem_addr = bp_q - W'(DSIZE); end
      OP_MG_RDN: begin mem_re = 1'b1; mem_addr = nb_q - W'(WSIZE); end
      OP_RM_RD0: begin mem_re = 1'b1; mem_addr = rm_q; end
      OP_RM_RD1: begin mem_re = 1'b1; mem_addr = rm_q + W'(WSIZE); end
      OP_RM_LINKP: begin
        mem_we = (p_q != '0); mem_addr = p_q + W'(WSIZE); mem_wd = mem_q;
      end
      OP_RM_LINKN: begin mem_we = (n_q != '0); mem_addr = n_q; mem_wd = 32'(p_q); end
      OP_INS0: begin mem_we = 1'b1; mem_addr = bp_q + W'(WSIZE); mem_wd = 32'(head_q); end
      OP_INS1: begin mem_we = 1'b1; mem_addr = bp_q; mem_wd = '0; end
      OP_INS2: begin mem_we = (head_q != '0); mem_addr = head_q; mem_wd = 32'(bp_q); end
      OP_A_RDH: begin mem_re = 1'b1; mem_addr = walk_q - W'(WSIZE); end
      OP_A_RDNX: begin mem_re = 1'b1; mem_addr = walk_q + W'(WSIZE); end
      OP_F_RD: begin mem_re = 1'b1; mem_addr = addr_w - W'(WSIZE); end
      default: begin end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we && (mem_addr < W'(HEAP_BYTES))) begin
      mem[mem_addr[WI+1:2]] <= mem_wd;
    end
    if (mem_re) begin
      mem_q <= mem[mem_addr[WI+1:2]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brk_q       <= '0;
      head_q      <= '0;
      ready_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_FINISH) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (cmd_i.op)
        OP_PRO0: begin brk_q <= W'(PRO_END); head_q <= '0; end
        OP_GROW_CHK: begin
          if (!grow_fail) begin
            brk_q <= brk_q + sz_q;
          end
        end
        OP_RM_LINKP: begin
          if (p_q == '0) begin
            head_q <= mem_q[W-1:0];
          end
        end
        OP_INS2: head_q <= bp_q;
        OP_SET_READY: ready_q <= ok_q;
        default: begin end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_CAPTURE: begin
        act_q  <= act_e'(action_i);
        req_q  <= request_bytes_i;
        addr_q <= block_addr_i;
        res_q  <= '0;
      end
      OP_PRO3: sz_q <= chunk_eff;
      OP_GROW_CHK: begin bp_q <= brk_q; ok_q <= !grow_fail; end
      OP_MG_RDP: nb_q <= bp_q + sz_q;
      OP_MG_RDN: begin psz_q <= mtag; pa_q <= mem_q[0]; pb_q <= bp_q - mtag; end
      OP_MG_LATN: begin nsz_q <= mtag; na_q <= mem_q[0]; end
      OP_MG_SUM: sz_q <= sz_q + (na_q ? '0 : nsz_q) + (pa_q ? '0 : psz_q);
      OP_MG_SETBP: begin
        if (!pa_q) begin
          bp_q <= pb_q;
        end
      end
      OP_RM_PB: rm_q <= pb_q;
      OP_RM_NB: rm_q <= nb_q;
      OP_RM_RD1: p_q <= mem_q[W-1:0];
      OP_RM_LINKP: n_q <= mem_q[W-1:0];
      OP_A_START: begin asz_q <= asize; walk_q <= head_q; steps_q <= '0; end
      OP_A_NEXT: begin walk_q <= mem_q[W-1:0]; steps_q <= steps_q + SW'(1); end
      OP_A_FOUND: begin bp_q <= walk_q; sz_q <= mtag; end
      OP_A_MISS: sz_q <= (asz_q > chunk_eff) ? asz_q : chunk_eff;
      OP_PL_START: begin res_q <= bp_q[15:0]; rm_q <= bp_q; end
      OP_PL_ASZ: begin csz_q <= sz_q; sz_q <= asz_q; end
      OP_PL_REM: begin bp_q <= bp_q + asz_q; sz_q <= csz_q - asz_q; end
      OP_F_CHK: begin ok_q <= free_ok; bp_q <= addr_w; sz_q <= mtag; end
      OP_FINISH: begin out_res_q <= res_q; out_st_q <= cmd_i.st; end
      default: begin end
    endcase
  end

  always_comb begin
    sts_o.ready    = ready_q;
    sts_o.req_zero = (req_q == '0);
    sts_o.act      = act_q;
    sts_o.ok       = ok_q;
    sts_o.pa       = pa_q;
    sts_o.na       = na_q;
    sts_o.fit      = (mtag >= asz_q) && !mem_q[0];
    sts_o.walk_end = (walk_q == '0) || (steps_q > SW'(STEP_MAX));
    sts_o.split    = (sz_q >= asz_q) && ((sz_q - asz_q) >= W'(MIN_BLK));
    sts_o.out_free = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o   = out_valid_q;
  assign result_addr_o = out_res_q;
  assign status_o      = out_st_q;

endmodule
`default_nettype wire

FILE: rtl/efla_ctrl.sv
// Controller: sequences init, allocate and free through grow, merge, remove.
// Depends on efla_pkg; drives efla_dp through cmd_t and reads sts_t.
`default_nettype none
module efla_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  efla_pkg::sts_t sts_i,
  output efla_pkg::cmd_t cmd_o
);
  import efla_pkg::*;

  localparam logic [5:0] S_IDLE    = 6'd0,  S_DISP    = 6'd1,  S_I0      = 6'd2,
                         S_I1      = 6'd3,  S_I2      = 6'd4,  S_I3      = 6'd5,
                         S_I_END   = 6'd6,  S_G_CHK   = 6'd7,  S_G_BR    = 6'd8,
                         S_G_HDR   = 6'd9,  S_G_FTR   = 6'd10, S_G_EPI   = 6'd11,
                         S_M0      = 6'd12, S_M1      = 6'd13, S_M2      = 6'd14,
                         S_M3      = 6'd15, S_M_RMP   = 6'd16, S_M_CHKN  = 6'd17,
                         S_M_RMN   = 6'd18, S_M_SET   = 6'd19, S_M_HDR   = 6'd20,
                         S_M_FTR   = 6'd21, S_M_INS0  = 6'd22, S_M_INS1  = 6'd23,
                         S_M_INS2  = 6'd24, S_R0      = 6'd25, S_R1      = 6'd26,
                         S_R2      = 6'd27, S_R3      = 6'd28, S_A_LOOP  = 6'd29,
                         S_A_CHK   = 6'd30, S_A_NX    = 6'd31, S_A_MISS  = 6'd32,
                         S_A_GROWN = 6'd33, S_PL0     = 6'd34, S_PL1     = 6'd35,
                         S_PL_HA   = 6'd36, S_PL_FA   = 6'd37, S_PL_REM  = 6'd38,
                         S_PL_HR   = 6'd39, S_PL_FR   = 6'd40, S_PL_HC   = 6'd41,
                         S_PL_FC   = 6'd42, S_F0      = 6'd43, S_F1      = 6'd44,
                         S_F2      = 6'd45, S_F_HDR   = 6'd46, S_F_FTR   = 6'd47,
                         S_DONE    = 6'd48;

  logic [5:0] state_q, state_d, ret_rm_q, ret_rm_d, ret_mg_q, ret_mg_d;
  logic [5:0] ret_gr_q, ret_gr_d;
  status_e    st_q, st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ret_rm_q <= S_IDLE;
      ret_mg_q <= S_IDLE;
      ret_gr_q <= S_IDLE;
      st_q     <= ST_OK;
    end else begin
      state_q  <= state_d;
      ret_rm_q <= ret_rm_d;
      ret_mg_q <= ret_mg_d;
      ret_gr_q <= ret_gr_d;
      st_q     <= st_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    ret_rm_d     = ret_rm_q;
    ret_mg_d     = ret_mg_q;
    ret_gr_d     = ret_gr_q;
    st_d         = st_q;
    cmd_o.op     = OP_NOP;
    cmd_o.alloc  = 1'b0;
    cmd_o.st     = st_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_CAPTURE;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        priority if (sts_i.act == ACT_INIT) begin
          state_d = S_I0;
        end else if (sts_i.act == ACT_NONE) begin
          st_d = ST_OK; state_d = S_DONE;
        end else if (!sts_i.ready) begin
          st_d = ST_NRDY; state_d = S_DONE;
        end else if (sts_i.act == ACT_FREE) begin
          st_d = ST_OK; state_d = S_F0;
        end else if (sts_i.req_zero) begin
          st_d = ST_ZERO; state_d = S_DONE;
        end else begin
          cmd_o.op = OP_A_START; state_d = S_A_LOOP;
        end
      end
      S_I0: begin cmd_o.op = OP_PRO0; state_d = S_I1; end
      S_I1: begin cmd_o.op = OP_PRO1; state_d = S_I2; end
      S_I2: begin cmd_o.op = OP_PRO2; state_d = S_I3; end
      S_I3: begin
        cmd_o.op = OP_PRO3; ret_gr_d = S_I_END; state_d = S_G_CHK;
      end
      S_I_END: begin
        cmd_o.op = OP_SET_READY;
        st_d     = sts_i.ok ? ST_OK : ST_OOM;
        state_d  = S_DONE;
      end
      S_G_CHK: begin cmd_o.op = OP_GROW_CHK; state_d = S_G_BR; end
      S_G_BR: state_d = sts_i.ok ? S_G_HDR : ret_gr_q;
      S_G_HDR: begin cmd_o.op = OP_HDR; state_d = S_G_FTR; end
      S_G_FTR: begin cmd_o.op = OP_FTR; state_d = S_G_EPI; end
      S_G_EPI: begin cmd_o.op = OP_EPI; ret_mg_d = ret_gr_q; state_d = S_M0; end
      S_M0: begin cmd_o.op = OP_MG_RDP; state_d = S_M1; end
      S_M1: begin cmd_o.op = OP_MG_RDN; state_d = S_M2; end
      S_M2: begin cmd_o.op = OP_MG_LATN; state_d = S_M3; end
      S_M3: begin
        cmd_o.op = OP_MG_SUM;
        priority if (!sts_i.pa) state_d = S_M_RMP;
        else if (!sts_i.na) state_d = S_M_RMN;
        else state_d = S_M_SET;
      end
      S_M_RMP: begin
        cmd_o.op = OP_RM_PB; ret_rm_d = S_M_CHKN; state_d = S_R0;
      end
      S_M_CHKN: state_d = sts_i.na ? S_M_SET : S_M_RMN;
      S_M_RMN: begin
        cmd_o.op = OP_RM_NB; ret_rm_d = S_M_SET; state_d = S_R0;
      end
      S_M_SET: begin cmd_o.op = OP_MG_SETBP; state_d = S_M_HDR; end
      S_M_HDR: begin cmd_o.op = OP_HDR; state_d = S_M_FTR; end
      S_M_FTR: begin cmd_o.op = OP_FTR; state_d = S_M_INS0; end
      S_M_INS0: begin cmd_o.op = OP_INS0; state_d = S_M_INS1; end
      S_M_INS1: begin cmd_o.op = OP_INS1; state_d = S_M_INS2; end
      S_M_INS2: begin cmd_o.op = OP_INS2; state_d = ret_mg_q; end
      S_R0: begin cmd_o.op = OP_RM_RD0; state_d = S_R1; end
      S_R1: begin cmd_o.op = OP_RM_RD1; state_d = S_R2; end
      S_R2: begin cmd_o.op = OP_RM_LINKP; state_d = S_R3; end
      S_R3: begin cmd_o.op = OP_RM_LINKN; state_d = ret_rm_q; end
      S_A_LOOP: begin
        if (sts_i.walk_end) begin
          state_d = S_A_MISS;
        end else begin
          cmd_o.op = OP_A_RDH; state_d = S_A_CHK;
        end
      end
      S_A_CHK: begin
        if (sts_i.fit) begin
          cmd_o.op = OP_A_FOUND; state_d = S_PL0;
        end else begin
          cmd_o.op = OP_A_RDNX; state_d = S_A_NX;
        end
      end
      S_A_NX: begin cmd_o.op = OP_A_NEXT; state_d = S_A_LOOP; end
      S_A_MISS: begin
        cmd_o.op = OP_A_MISS; ret_gr_d = S_A_GROWN; state_d = S_G_CHK;
      end
      S_A_GROWN: begin
        if (sts_i.ok) begin
          state_d = S_PL0;
        end else begin
          st_d = ST_OOM; state_d = S_DONE;
        end
      end
      S_PL0: begin
        cmd_o.op = OP_PL_START; st_d = ST_OK; ret_rm_d = S_PL1; state_d = S_R0;
      end
      S_PL1: begin
        if (sts_i.split) begin
          cmd_o.op = OP_PL_ASZ; state_d = S_PL_HA;
        end else begin
          state_d = S_PL_HC;
        end
      end
      S_PL_HA: begin cmd_o.op = OP_HDR; cmd_o.alloc = 1'b1; state_d = S_PL_FA; end
      S_PL_FA: begin cmd_o.op = OP_FTR; cmd_o.alloc = 1'b1; state_d = S_PL_REM; end
      S_PL_REM: begin cmd_o.op = OP_PL_REM; state_d = S_PL_HR; end
      S_PL_HR: begin cmd_o.op = OP_HDR; state_d = S_PL_FR; end
      S_PL_FR: begin
        cmd_o.op = OP_FTR; ret_mg_d = S_DONE; state_d = S_M0;
      end
      S_PL_HC: begin cmd_o.op = OP_HDR; cmd_o.alloc = 1'b1; state_d = S_PL_FC; end
      S_PL_FC: begin cmd_o.op = OP_FTR; cmd_o.alloc = 1'b1; state_d = S_DONE; end
      S_F0: begin cmd_o.op = OP_F_RD; state_d = S_F1; end
      S_F1: begin cmd_o.op = OP_F_CHK; state_d = S_F2; end
      S_F2: state_d = sts_i.ok ? S_F_HDR : S_DONE;
      S_F_HDR: begin cmd_o.op = OP_HDR; state_d = S_F_FTR; end
      S_F_FTR: begin
        cmd_o.op = OP_FTR; ret_mg_d = S_DONE; state_d = S_M0;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_FINISH; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule
`default_nettype wire

FILE: rtl/explicit_free_list_heap_allocator.sv
// Top level: APB chunk register, controller and datapath of the heap allocator.
// Depends on efla_pkg, efla_ctrl and efla_dp.
//
//   channel  | signals                                         | direction
//   input    | in_valid_i/in_stall_o, action_i, request_bytes_i, block_addr_i | in
//   output   | out_valid_o/out_stall_i, result_addr_o, status_o | out
//   config   | psel, penable, pwrite, paddr, pwdata, prdata, pready | APB
//
// One word at a time; the single-port heap memory sets the pace.
// Init writes prologue and epilogue, then grows the heap. Free checks the
// header; if valid it writes header and footer and merges free neighbors.
// Allocate walks the free list, grows the heap on a miss and places the
// block, split or whole. The result register frees the controller while
// a result waits; the next word is taken once the controller is back idle.
// Reset clears break, list head and ready; the heap memory is not cleared.
`default_nettype none
module explicit_free_list_heap_allocator #(
  parameter int unsigned HEAP_BYTES = efla_pkg::HEAP_BYTES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  action_i,
  input  logic [16:0]                 request_bytes_i,
  input  logic [15:0]                 block_addr_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [15:0]                 result_addr_o,
  output logic [1:0]                  status_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [efla_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import efla_pkg::*;

  logic [CHUNK_W-1:0] chunk_q;
  cmd_t cmd;
  sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q <= CHUNK_RST;
    end else if (psel && penable && pwrite && (paddr == CFG_CHUNK_ADDR)) begin
      chunk_q <= pwdata[CHUNK_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == CFG_CHUNK_ADDR) ? 32'(chunk_q) : '0;

  efla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  efla_dp #(
    .HEAP_BYTES (HEAP_BYTES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .action_i        (action_i),
    .request_bytes_i (request_bytes_i),
    .block_addr_i    (block_addr_i),
    .chunk_i         (chunk_q),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .result_addr_o   (result_addr_o),
    .status_o        (status_o)
  );

endmodule
`default_nettype wire

FILE: rtl/efla_chk.sv
// Port-level checker for the heap allocator, bound to the top level.
// Depends on efla_pkg and explicit_free_list_heap_allocator.
`default_nettype none
module efla_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] result_addr_o,
  input logic [1:0]  status_o,
  input logic        pready
);
  import efla_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_addr_o))
    else $error("stalled result dropped or changed");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> result_addr_o == '0)
    else $error("failed request returned an address");

  a_addr_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_addr_o != '0) |->
      (result_addr_o[2:0] == 3'b000) && (result_addr_o >= 16'(PRO_END)))
    else $error("returned address misaligned or inside prologue");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind explicit_free_list_heap_allocator efla_chk u_efla_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .result_addr_o (result_addr_o),
  .status_o      (status_o),
  .pready        (pready)
);
`default_nettype wire
